// ===== design/fbfl_pkg.sv =====
package fbfl_pkg;

  // Fixed field widths of the command and result words.
  localparam int SLOT_W  = 10;
  localparam int CFG_W   = 11;
  localparam int COUNT_W = 11;

  // Defaults and limits.
  localparam int DEF_POOL_SLOTS = 1024;
  localparam logic [CFG_W-1:0] SLOT_CAP_RESET    = 11'd0;
  localparam logic [CFG_W-1:0] CHUNK_ITEMS_RESET = 11'd16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

  // Configuration register indexes.
  localparam logic CFG_SLOT_CAP    = 1'b0;
  localparam logic CFG_CHUNK_ITEMS = 1'b1;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_LIMIT     = 2'd1,
    ST_EXHAUSTED = 2'd2,
    ST_NULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CARVE
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [SLOT_W-1:0] slot;
    logic              slot_valid;
  } in_word_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  granted_slot;
    status_t            status;
    logic [COUNT_W-1:0] in_use_count;
  } out_word_t;

endpackage

// ===== design/fbfl_link_ram.sv =====
module fbfl_link_ram #(
  parameter int DEPTH  = fbfl_pkg::DEF_POOL_SLOTS,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [ADDR_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [ADDR_W-1:0] rd_data
);

  // Next-link storage: one write port, one registered read port.
  logic [ADDR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/fbfl_ctrl.sv =====
module fbfl_ctrl #(
  parameter int POOL_SLOTS = fbfl_pkg::DEF_POOL_SLOTS,
  parameter int IDX_W      = $clog2(POOL_SLOTS)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  fbfl_pkg::in_word_t            in_word,
  input  logic [IDX_W-1:0]              slot_idx,
  output logic                          out_valid,
  output fbfl_pkg::out_word_t           out_word,
  input  logic [fbfl_pkg::CFG_W-1:0]    slot_cap,
  input  logic [fbfl_pkg::CFG_W-1:0]    chunk_items,
  output logic                          mem_wr_en,
  output logic [IDX_W-1:0]              mem_wr_addr,
  output logic [IDX_W-1:0]              mem_wr_data,
  output logic                          mem_rd_en,
  output logic [IDX_W-1:0]              mem_rd_addr,
  input  logic [IDX_W-1:0]              mem_rd_data
);

  import fbfl_pkg::*;

  localparam int CNT_W  = $clog2(POOL_SLOTS + 1);
  localparam int EXT_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int WIDE_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic               empty_r, empty_nxt;
  logic [CNT_W-1:0]   carved_r, carved_nxt;
  logic [COUNT_W-1:0] in_use_r, in_use_nxt;
  logic [IDX_W-1:0]   fill_r, fill_nxt;
  logic [IDX_W-1:0]   base_r, base_nxt;
  logic [IDX_W-1:0]   top_r, top_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_word_r, out_word_nxt;

  logic               accept;
  logic               limit_hit;
  logic               pool_full;
  logic [COUNT_W-1:0] in_use_inc;
  logic [COUNT_W-1:0] in_use_dec;
  logic [EXT_W-1:0]   chunk_eff;
  logic [EXT_W-1:0]   remaining;
  logic [EXT_W-1:0]   carve_n;
  logic [EXT_W-1:0]   carve_top;
  logic [EXT_W-1:0]   carved_sum;

  // Maps an internal slot index onto the 10-bit result field.
  function automatic logic [SLOT_W-1:0] to_out_slot(input logic [IDX_W-1:0] s);
    logic [WIDE_W-1:0] w;
    w = WIDE_W'(s);
    return w[SLOT_W-1:0];
  endfunction

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Conditions shared by the control and datapath blocks.
  assign limit_hit  = (slot_cap != '0) && (in_use_r >= slot_cap);
  assign pool_full  = (carved_r >= CNT_W'(POOL_SLOTS));
  assign in_use_inc = (in_use_r != COUNT_MAX) ? in_use_r + 1'b1 : in_use_r;
  assign in_use_dec = (in_use_r != '0) ? in_use_r - 1'b1 : in_use_r;

  // Size of the next chunk, clipped to the uncarved part of the pool.
  assign chunk_eff  = (chunk_items == '0) ? EXT_W'(1) : EXT_W'(chunk_items);
  assign remaining  = EXT_W'(POOL_SLOTS) - EXT_W'(carved_r);
  assign carve_n    = (chunk_eff > remaining) ? remaining : chunk_eff;
  assign carve_top  = EXT_W'(carved_r) + carve_n - EXT_W'(1);
  assign carved_sum = EXT_W'(carved_r) + carve_n;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_word.op == OP_ALLOC) && !limit_hit) begin
          if (!empty_r) begin
            state_nxt = S_READ;
          end else if (!pool_full) begin
            state_nxt = S_CARVE;
          end
        end
      end
      S_READ: begin
        state_nxt = S_IDLE;
      end
      S_CARVE: begin
        if (fill_r == top_r) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Datapath, memory requests and result word.
  always_comb begin
    head_nxt      = head_r;
    empty_nxt     = empty_r;
    carved_nxt    = carved_r;
    in_use_nxt    = in_use_r;
    fill_nxt      = fill_r;
    base_nxt      = base_r;
    top_nxt       = top_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = fill_r;
    mem_wr_data   = fill_r;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = head_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_word.op == OP_ALLOC) begin
            if (limit_hit) begin
              out_valid_nxt = 1'b1;
              out_word_nxt  = '{granted_slot: '0, status: ST_LIMIT, in_use_count: in_use_r};
            end else if (!empty_r) begin
              // Fetch the head's link; the pop completes next cycle.
              mem_rd_en = 1'b1;
            end else if (pool_full) begin
              out_valid_nxt = 1'b1;
              out_word_nxt  = '{granted_slot: '0, status: ST_EXHAUSTED,
                                in_use_count: in_use_r};
            end else begin
              // Open a new chunk; its links are written one per cycle.
              base_nxt   = IDX_W'(carved_r);
              fill_nxt   = IDX_W'(carved_r);
              top_nxt    = IDX_W'(carve_top);
              carved_nxt = CNT_W'(carved_sum);
            end
          end else if (!in_word.slot_valid) begin
            out_valid_nxt = 1'b1;
            out_word_nxt  = '{granted_slot: '0, status: ST_NULL, in_use_count: in_use_r};
          end else begin
            // Push the released slot in front of the current head.
            mem_wr_en     = 1'b1;
            mem_wr_addr   = slot_idx;
            mem_wr_data   = empty_r ? slot_idx : head_r;
            head_nxt      = slot_idx;
            empty_nxt     = 1'b0;
            in_use_nxt    = in_use_dec;
            out_valid_nxt = 1'b1;
            out_word_nxt  = '{granted_slot: '0, status: ST_OK, in_use_count: in_use_dec};
          end
        end
      end
      S_READ: begin
        // A link that points to itself marks the last slot on the list.
        if (mem_rd_data == head_r) begin
          empty_nxt = 1'b1;
        end else begin
          head_nxt = mem_rd_data;
        end
        in_use_nxt    = in_use_inc;
        out_valid_nxt = 1'b1;
        out_word_nxt  = '{granted_slot: to_out_slot(head_r), status: ST_OK,
                          in_use_count: in_use_inc};
      end
      S_CARVE: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = fill_r;
        mem_wr_data = (fill_r == base_r) ? base_r : fill_r - 1'b1;
        fill_nxt    = fill_r + 1'b1;
        if (fill_r == top_r) begin
          // The top slot of the chunk is handed out right away.
          if (top_r == base_r) begin
            head_nxt  = top_r;
            empty_nxt = 1'b1;
          end else begin
            head_nxt  = top_r - 1'b1;
            empty_nxt = 1'b0;
          end
          in_use_nxt    = in_use_inc;
          out_valid_nxt = 1'b1;
          out_word_nxt  = '{granted_slot: to_out_slot(top_r), status: ST_OK,
                            in_use_count: in_use_inc};
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      empty_r     <= 1'b1;
      carved_r    <= '0;
      in_use_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      empty_r     <= empty_nxt;
      carved_r    <= carved_nxt;
      in_use_r    <= in_use_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    fill_r     <= fill_nxt;
    base_r     <= base_nxt;
    top_r      <= top_nxt;
    out_word_r <= out_word_nxt;
  end

  // A link read always produces a result in the following cycle.
  a_read_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |=> out_valid_r)
    else $error("link read finished without a result");

  // The carve sweep never runs past the top of its chunk.
  a_fill_in_chunk: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CARVE |-> (fill_r >= base_r) && (fill_r <= top_r))
    else $error("carve sweep outside its chunk");

  // The carved count never exceeds the pool.
  a_carved_bound: assert property (@(posedge clk) disable iff (!rst_n)
    carved_r <= CNT_W'(POOL_SLOTS))
    else $error("carved count beyond pool size");

  // Only a successful allocate names a slot.
  a_slot_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_word_r.status != ST_OK) |-> out_word_r.granted_slot == '0)
    else $error("failed item reported a slot");

  // Memory write and read never share a cycle.
  a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_wr_en && mem_rd_en))
    else $error("link memory read and write in one cycle");

endmodule

// ===== design/fixed_block_free_list_allocator.sv =====
// Channel  Ports                          Direction  Handshake
// in       start, busy, in_word           input      taken when start && !busy
// out      out_valid, out_word            output     one-cycle strobe, no stall
// cfg      cfg_we, cfg_index, cfg_data    input      written when cfg_we is high
//
// Release, null release, limit hit and exhausted pool: the result is registered in the
// cycle after the word is taken, and the next word may follow at once.
// Allocate from the list: the head's link is read synchronously, then S_READ pops it.
// Allocate that opens a chunk of n slots: one link memory write per slot in S_CARVE.
// Reset (rst_n low, synchronous) empties the list and clears both counts; the link
// memory needs no clearing. Results cannot be stalled by the receiver.
module fixed_block_free_list_allocator #(
  parameter int POOL_SLOTS = fbfl_pkg::DEF_POOL_SLOTS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  fbfl_pkg::in_word_t         in_word,
  output logic                       out_valid,
  output fbfl_pkg::out_word_t        out_word,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [fbfl_pkg::CFG_W-1:0] cfg_data
);

  import fbfl_pkg::*;

  localparam int IDX_W = $clog2(POOL_SLOTS);

  logic [CFG_W-1:0] slot_cap_r;
  logic [CFG_W-1:0] chunk_items_r;
  logic [31:0]      slot_mod;
  logic [IDX_W-1:0] slot_idx;
  logic             mem_wr_en;
  logic [IDX_W-1:0] mem_wr_addr;
  logic [IDX_W-1:0] mem_wr_data;
  logic             mem_rd_en;
  logic [IDX_W-1:0] mem_rd_addr;
  logic [IDX_W-1:0] mem_rd_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_cap_r    <= SLOT_CAP_RESET;
      chunk_items_r <= CHUNK_ITEMS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SLOT_CAP:    slot_cap_r    <= cfg_data;
        CFG_CHUNK_ITEMS: chunk_items_r <= cfg_data;
        default:         slot_cap_r    <= slot_cap_r;
      endcase
    end
  end

  // Fold the released slot into the pool range by scaled compare and subtract.
  always_comb begin
    slot_mod = 32'(in_word.slot);
    for (int k = 6; k >= 0; k--) begin
      if (slot_mod >= (32'(POOL_SLOTS) << k)) begin
        slot_mod = slot_mod - (32'(POOL_SLOTS) << k);
      end
    end
  end

  assign slot_idx = slot_mod[IDX_W-1:0];

  fbfl_ctrl #(
    .POOL_SLOTS (POOL_SLOTS),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_word     (in_word),
    .slot_idx    (slot_idx),
    .out_valid   (out_valid),
    .out_word    (out_word),
    .slot_cap    (slot_cap_r),
    .chunk_items (chunk_items_r),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  fbfl_link_ram #(
    .DEPTH  (POOL_SLOTS),
    .ADDR_W (IDX_W)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule
